### hw/rtl/mstt_pkg.sv
// Shared types and constants for the software timer table.
package mstt_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W       = 16;
  localparam int IVL_W      = 16;
  localparam int TIME_W     = 26;
  localparam int MS_PER_SEC = 1000;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_REG   = 2'd1,
    MODE_UNREG = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_REGISTERED = 3'd0,
    EV_FULL       = 3'd1,
    EV_REMOVED    = 3'd2,
    EV_NOT_FOUND  = 3'd3,
    EV_FIRED      = 3'd4,
    EV_QUIET      = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One timer slot as it travels around the ring.
  typedef struct packed {
    logic              used;
    logic              one_shot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] elapsed;
    logic [ID_W-1:0]   ident;
  } slot_t;

endpackage

### hw/rtl/mstt_cell.sv
// One timer slot of the ring; takes its neighbor's slot on every shift.
module mstt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  mstt_pkg::slot_t slot_i,
  output mstt_pkg::slot_t slot_o
);
  import mstt_pkg::*;

  logic              used_r;
  logic              one_shot_r;
  logic [TIME_W-1:0] period_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [ID_W-1:0]   ident_r;

  // flags reset, counts and id only matter once used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= 1'b0;
      one_shot_r <= 1'b0;
    end else if (shift_en) begin
      used_r     <= slot_i.used;
      one_shot_r <= slot_i.one_shot;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      period_r  <= slot_i.period;
      elapsed_r <= slot_i.elapsed;
      ident_r   <= slot_i.ident;
    end
  end

  always_comb begin
    slot_o.used     = used_r;
    slot_o.one_shot = one_shot_r;
    slot_o.period   = period_r;
    slot_o.elapsed  = elapsed_r;
    slot_o.ident    = ident_r;
  end

endmodule

### hw/rtl/multi_slot_software_timer_table_unit.sv
// Top level of the software timer table: slot ring, head logic and result register.
// Input stream (in_*): one beat per command. in_tuser carries the mode
//   (tick, register, unregister); in_tdata carries the register/unregister
//   arguments. A mode of three is taken and dropped without any result.
// Output stream (out_*): result beats. out_tuser is the event code, out_tdata
//   the timer id (zero where none applies), out_tlast marks the final beat
//   caused by one command.
// Timing: the slots sit in a ring of SLOTS cells; a command walks the whole
//   ring once, one slot per cycle unless a flushed fire waits on the output
//   register, through the head logic at cell 0. The last result beat shows
//   with in_tready back high in the same cycle, so the next command can be
//   accepted then. A tick emits up to SLOTS fired beats, at most one per cycle.
// Reset: rst_n (synchronous, active low) frees every slot and zeroes the id
//   counter; the first registered timer gets id 1. No clearing pass.
// Backpressure: results sit in an output register. When out_tready is low and
//   a further result is due, the ring stops shifting until the beat is taken;
//   no result is lost. in_tready is high only between commands.
module multi_slot_software_timer_table_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input command stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mstt_pkg::IN_DATA_W-1:0]     in_tdata,  // one_shot, unit_seconds,
                                                        // interval[15:0], drop_id[15:0], zero pad
  input  logic [1:0]                         in_tuser,  // mode[1:0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mstt_pkg::OUT_DATA_W-1:0]    out_tdata, // id_out[15:0]
  output logic [2:0]                         out_tuser, // event_res[2:0]
  output logic                               out_tlast  // last
);
  import mstt_pkg::*;

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic             f_one_shot;
  logic             f_unit_seconds;
  logic [IVL_W-1:0] f_interval;
  logic [ID_W-1:0]  f_drop_id;
  logic [TIME_W-1:0] f_period_ms;

  assign f_one_shot     = in_tdata[0];
  assign f_unit_seconds = in_tdata[1];
  assign f_interval     = in_tdata[2 +: IVL_W];
  assign f_drop_id      = in_tdata[2 + IVL_W +: ID_W];

  // seconds scale to ms; 65535 s still fits 26 bits
  assign f_period_ms = f_unit_seconds ?
                       (TIME_W'(f_interval) * TIME_W'(MS_PER_SEC)) :
                       TIME_W'(f_interval);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] step_r, step_nxt;
  mode_t             cmd_mode_r;
  logic              cmd_once_r;
  logic [TIME_W-1:0] cmd_period_r;
  logic [ID_W-1:0]   cmd_tid_r;
  logic [ID_W-1:0]   id_counter_r, id_counter_nxt;
  logic              found_r, found_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [ID_W-1:0]   held_id_r, held_id_nxt;

  logic              out_valid_r;
  event_t            out_ev_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;

  // result push from control
  logic              push;
  event_t            push_ev;
  logic [ID_W-1:0]   push_id;
  logic              push_last;
  logic              out_free;

  logic              advance;
  logic              in_acc;

  // ---------------------------------------------------------------------------
  // Slot ring
  // ---------------------------------------------------------------------------
  slot_t ring_q [SLOTS];
  slot_t head_in;
  slot_t head_out;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      slot_t cell_d;
      if (gi == SLOTS - 1) begin : g_tail
        assign cell_d = head_out;
      end else begin : g_mid
        assign cell_d = ring_q[gi + 1];
      end
      mstt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (advance),
        .slot_i   (cell_d),
        .slot_o   (ring_q[gi])
      );
    end
  endgenerate

  assign head_in = ring_q[0];

  // ---------------------------------------------------------------------------
  // Head logic: unless a flushed fire stalls the ring, one slot per cycle
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] el_inc;
  logic              fire;
  logic              take;
  logic              hit;
  logic [ID_W-1:0]   id_next;

  assign el_inc  = head_in.elapsed + TIME_W'(1);
  assign fire    = head_in.used && (head_in.period <= el_inc);
  assign take    = !head_in.used && !found_r;
  assign hit     = head_in.used && (head_in.ident == cmd_tid_r) && !found_r;
  assign id_next = (id_counter_r == {ID_W{1'b1}}) ? ID_W'(1) : id_counter_r + ID_W'(1);

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    head_out       = head_in;
    state_nxt      = state_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    held_valid_nxt = held_valid_r;
    held_id_nxt    = held_id_r;
    id_counter_nxt = id_counter_r;
    push           = 1'b0;
    push_ev        = EV_QUIET;
    push_id        = '0;
    push_last      = 1'b0;
    advance        = 1'b0;

    case (cmd_mode_r)
      MODE_TICK: begin
        if (head_in.used) begin
          head_out.elapsed = fire ? '0 : el_inc;
          head_out.used    = !(fire && head_in.one_shot);
        end
      end
      MODE_REG: begin
        if (take) begin
          head_out.used     = 1'b1;
          head_out.one_shot = cmd_once_r;
          head_out.period   = cmd_period_r;
          head_out.elapsed  = '0;
          head_out.ident    = id_next;
        end
      end
      MODE_UNREG: begin
        if (hit) begin
          head_out.used = 1'b0;
        end
      end
      default: begin
        head_out = head_in;
      end
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (mode_t'(in_tuser) != MODE_NONE)) begin
          state_nxt      = ST_SCAN;
          step_nxt       = '0;
          found_nxt      = 1'b0;
          held_valid_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        // an earlier fire is flushed (not last) when a newer one arrives
        if (cmd_mode_r == MODE_TICK && fire && held_valid_r) begin
          advance = out_free;
          push    = out_free;
          push_ev = EV_FIRED;
          push_id = held_id_r;
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          case (cmd_mode_r)
            MODE_TICK: begin
              if (fire) begin
                held_valid_nxt = 1'b1;
                held_id_nxt    = head_in.ident;
              end
            end
            MODE_REG: begin
              if (take) begin
                found_nxt      = 1'b1;
                id_counter_nxt = id_next;
              end
            end
            MODE_UNREG: begin
              if (hit) begin
                found_nxt = 1'b1;
              end
            end
            default: begin
              found_nxt = found_r;
            end
          endcase
          if (step_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            step_nxt = step_r + SLOT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          case (cmd_mode_r)
            MODE_TICK: begin
              push_ev = held_valid_r ? EV_FIRED : EV_QUIET;
              push_id = held_valid_r ? held_id_r : '0;
            end
            MODE_REG: begin
              push_ev = found_r ? EV_REGISTERED : EV_FULL;
              push_id = found_r ? id_counter_r : '0;
            end
            MODE_UNREG: begin
              push_ev = found_r ? EV_REMOVED : EV_NOT_FOUND;
              push_id = found_r ? cmd_tid_r : '0;
            end
            default: begin
              push = 1'b0;
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      found_r      <= 1'b0;
      held_valid_r <= 1'b0;
      id_counter_r <= '0;
      cmd_mode_r   <= MODE_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      found_r      <= found_nxt;
      held_valid_r <= held_valid_nxt;
      id_counter_r <= id_counter_nxt;
      if (in_acc) begin
        cmd_mode_r <= mode_t'(in_tuser);
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command arguments and result payload
  always_ff @(posedge clk) begin
    held_id_r <= held_id_nxt;
    if (in_acc) begin
      cmd_once_r   <= f_one_shot;
      cmd_period_r <= f_period_ms;
      cmd_tid_r    <= f_drop_id;
    end
    if (push) begin
      out_ev_r   <= push_ev;
      out_id_r   <= push_id;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = out_id_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && advance && step_r == SLOT_W'(SLOTS - 1)) |=> (state_r == ST_DONE))
    else $error("ring walk did not end after the last slot");

  a_held_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (held_valid_r && state_r != ST_IDLE) |-> (cmd_mode_r == MODE_TICK))
    else $error("held fire outside a tick");

  a_found_not_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r != ST_IDLE) |-> (cmd_mode_r != MODE_TICK))
    else $error("slot match flag set on a tick");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (id_counter_r != '0) |=> (id_counter_r != '0))
    else $error("id counter fell back to zero");

  a_final_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_tvalid && out_tlast))
    else $error("final result beat missing");

endmodule

### bench/tb_multi_slot_software_timer_table_unit.sv
// Self-checking testbench for the software timer table: stimulus, predictor and result checker.
`timescale 1ns / 1ps

module tb_multi_slot_software_timer_table_unit;
  import mstt_pkg::*;

  // One expected result beat, packed as {last, event, id}.
  typedef struct packed {
    logic              last;
    event_t            ev;
    logic [ID_W-1:0]   id;
  } timer_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;  // one_shot, unit_seconds, interval[15:0], drop_id[15:0], pad
  logic [1:0]            in_tuser;  // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata; // id_out[15:0]
  logic [2:0]            out_tuser; // event_res[2:0]
  logic                  out_tlast; // last

  multi_slot_software_timer_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // Shadow copy of the timer table, updated on every accepted command beat.
  bit                tm_used     [SLOTS];
  bit                tm_one_shot [SLOTS];
  logic [TIME_W-1:0] tm_period   [SLOTS];
  logic [TIME_W-1:0] tm_elapsed  [SLOTS];
  logic [ID_W-1:0]   tm_ident    [SLOTS];
  logic [ID_W-1:0]   tm_id_count;

  timer_beat_t       timer_beats_due[$];  // results still owed by the block, oldest first
  int                mismatches;

  // Traffic shaping knobs, in percent.
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_cycles;         // long receiver hold-off, counted down below

  // Work out the results of one command and advance the shadow table.
  function automatic void predict_timer_table(mode_t mode, bit once, bit secs,
                                              logic [IVL_W-1:0] ivl, logic [ID_W-1:0] tid);
    int          free_slot;
    int          fired;
    bit          found;
    timer_beat_t tail;
    free_slot = -1;
    fired     = 0;
    found     = 1'b0;
    case (mode)
      MODE_TICK: begin
        // every live timer counts one ms; due ones fire in slot order
        for (int i = 0; i < SLOTS; i++) begin
          if (tm_used[i]) begin
            tm_elapsed[i] = tm_elapsed[i] + 1'b1;
            if (tm_period[i] <= tm_elapsed[i]) begin
              timer_beats_due.push_back({1'b0, EV_FIRED, tm_ident[i]});
              fired++;
              tm_elapsed[i] = '0;
              if (tm_one_shot[i]) tm_used[i] = 1'b0;
            end
          end
        end
        if (fired == 0) timer_beats_due.push_back({1'b0, EV_QUIET, 16'd0});
      end
      MODE_REG: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!tm_used[i]) free_slot = i;
        if (free_slot < 0) begin
          // table full: id counter holds
          timer_beats_due.push_back({1'b0, EV_FULL, 16'd0});
        end else begin
          tm_id_count            = (tm_id_count == 16'hFFFF) ? 16'd1 : tm_id_count + 1'b1;
          tm_used[free_slot]     = 1'b1;
          tm_one_shot[free_slot] = once;
          tm_period[free_slot]   = secs ? TIME_W'(ivl) * TIME_W'(MS_PER_SEC) : TIME_W'(ivl);
          tm_elapsed[free_slot]  = '0;
          tm_ident[free_slot]    = tm_id_count;
          timer_beats_due.push_back({1'b0, EV_REGISTERED, tm_id_count});
        end
      end
      MODE_UNREG: begin
        // only the lowest slot holding the id goes
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && tm_used[i] && tm_ident[i] == tid) begin
            tm_used[i] = 1'b0;
            found      = 1'b1;
          end
        end
        if (found) timer_beats_due.push_back({1'b0, EV_REMOVED, tid});
        else       timer_beats_due.push_back({1'b0, EV_NOT_FOUND, 16'd0});
      end
      default: ;  // mode three: dropped silently
    endcase
    if (mode != MODE_NONE) begin
      tail      = timer_beats_due.pop_back();
      tail.last = 1'b1;
      timer_beats_due.push_back(tail);
    end
  endfunction

  // Offer one command beat, hold it until taken, then predict its results.
  task automatic send_command(mode_t mode, bit once, bit secs,
                              logic [IVL_W-1:0] ivl, logic [ID_W-1:0] tid);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? int'($urandom_range(6, 1)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= mode;
    in_tdata  <= {6'd0, tid, ivl, secs, once};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_timer_table(mode, once, secs, ivl, tid);
  endtask

  // Unused fields carry random noise; the block must ignore them.
  task automatic tick_cmd();
    send_command(MODE_TICK, 1'($urandom), 1'($urandom), IVL_W'($urandom), ID_W'($urandom));
  endtask

  task automatic reg_cmd(bit once, bit secs, logic [IVL_W-1:0] ivl);
    send_command(MODE_REG, once, secs, ivl, ID_W'($urandom));
  endtask

  task automatic unreg_cmd(logic [ID_W-1:0] tid);
    send_command(MODE_UNREG, 1'($urandom), 1'($urandom), IVL_W'($urandom), tid);
  endtask

  // Sender goes quiet until every owed result has been taken.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (timer_beats_due.size() != 0);
  endtask

  // Random command: mostly short timers so ticks keep firing, plus some
  // full-range intervals and ids to walk every bit.
  task automatic random_command();
    int               pick;
    int               r;
    int               live[$];
    bit               secs;
    logic [IVL_W-1:0] ivl;
    logic [ID_W-1:0]  tid;
    pick = $urandom_range(99);
    if (pick < 40) begin
      tick_cmd();
    end else if (pick < 72) begin
      r = $urandom_range(9);
      if (r < 6) begin
        secs = 1'b0;
        ivl  = IVL_W'($urandom_range(6));
      end else if (r < 8) begin
        secs = 1'b1;
        ivl  = IVL_W'($urandom_range(1));
      end else begin
        secs = r[0];
        ivl  = IVL_W'($urandom);
      end
      reg_cmd(1'($urandom), secs, ivl);
    end else if (pick < 95) begin
      for (int i = 0; i < SLOTS; i++) if (tm_used[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(3) != 0)
        tid = tm_ident[live[$urandom_range(live.size() - 1)]];
      else
        tid = ID_W'($urandom);
      unreg_cmd(tid);
    end else begin
      send_command(MODE_NONE, 1'($urandom), 1'($urandom), IVL_W'($urandom), ID_W'($urandom));
    end
  endtask

  // Directed: quiet tick, ignored mode, missing ids, zero and largest
  // intervals in both units, one-shot release, a full table and a tick
  // that fires a long run of timers.
  task automatic test_directed();
    tick_cmd();
    send_command(MODE_NONE, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    unreg_cmd(16'd0);           // id 0 is never handed out
    reg_cmd(1'b0, 1'b0, 16'd0);       // id 1: fires every tick
    reg_cmd(1'b1, 1'b0, 16'd1);       // id 2: one-shot, 1 ms
    reg_cmd(1'b0, 1'b1, 16'hFFFF);    // id 3: longest interval
    reg_cmd(1'b1, 1'b1, 16'd0);       // id 4: zero seconds, one-shot
    reg_cmd(1'b1, 1'b0, 16'hFFFF);    // id 5: longest ms interval
    tick_cmd();
    tick_cmd();
    unreg_cmd(16'd3);
    unreg_cmd(16'd3);           // already gone
    for (int i = 0; i < 14; i++) reg_cmd(i[0], 1'b0, 16'd0);
    reg_cmd(1'b0, 1'b0, 16'd5);       // no room left
    tick_cmd();
  endtask

  task automatic test_random(int count);
    repeat (count) random_command();
  endtask

  // Receiver goes dark for a long stretch while commands keep coming, so the
  // output register and ring back up into in_tready.
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      if (i[0]) tick_cmd();
      else      reg_cmd(1'($urandom), 1'b0, 16'd0);
    end
  endtask

  // Sender pauses with the pipeline fully empty, then resumes.
  task automatic test_drain_pause();
    test_random(8);
    wait_drain();
    test_random(8);
  endtask

  // Receiver: random stalls, overridden by the long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every taken result beat is matched against the oldest one owed.
  always @(posedge clk) begin : check_results
    timer_beat_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (timer_beats_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected beat: expected none, got event %0d id %0d last %0b",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = timer_beats_due.pop_front();
        if (out_tuser !== want.ev || out_tdata !== want.id || out_tlast !== want.last) begin
          mismatches++;
          $display("%0t ns: result mismatch: expected event %0d id %0d last %0b, got event %0d id %0d last %0b",
                   $time, want.ev, want.id, want.last, out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = MODE_TICK;
    out_tready     = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    tm_id_count    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tm_used[i]     = 1'b0;
      tm_one_shot[i] = 1'b0;
      tm_period[i]   = '0;
      tm_elapsed[i]  = '0;
      tm_ident[i]    = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();

    // random traffic under each idling mix
    test_random(38);
    send_idle_pct = 61;
    test_random(38);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    test_random(38);
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    test_random(38);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_drain_pause();

    // drain, then give the ring more walks to show any stray beat
    wait_drain();
    repeat (4 * (SLOTS + 2)) @(posedge clk);
    if (mismatches == 0 && timer_beats_due.size() == 0)
      $display("tb_multi_slot_software_timer_table_unit passed");
    else
      $display("tb_multi_slot_software_timer_table_unit failed");
    $finish;
  end

  // Watchdog: a full run needs well under 1 ms even with every tick firing
  // the whole table under heavy stalls.
  initial begin
    #10_000_000;
    $display("tb_multi_slot_software_timer_table_unit failed");
    $finish;
  end

endmodule
